// ===== design/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the script token scanner
// Token kind codes, scanner modes, keyword tables and the queue entry type.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned PosBits  = 16;
  localparam int unsigned LineBits = 16;
  localparam logic [PosBits-1:0]  PosTop  = '1;
  localparam logic [LineBits-1:0] LineTop = '1;

  // token kinds
  localparam logic [5:0] KEof     = 6'd0;
  localparam logic [5:0] KLParen  = 6'd1;
  localparam logic [5:0] KRParen  = 6'd2;
  localparam logic [5:0] KLBrace  = 6'd3;
  localparam logic [5:0] KRBrace  = 6'd4;
  localparam logic [5:0] KSemi    = 6'd5;
  localparam logic [5:0] KComma   = 6'd6;
  localparam logic [5:0] KDot     = 6'd7;
  localparam logic [5:0] KMinus   = 6'd8;
  localparam logic [5:0] KPlus    = 6'd9;
  localparam logic [5:0] KSlash   = 6'd10;
  localparam logic [5:0] KStar    = 6'd11;
  localparam logic [5:0] KAmp     = 6'd12;
  localparam logic [5:0] KPipe    = 6'd14;
  localparam logic [5:0] KBang    = 6'd16;
  localparam logic [5:0] KEqual   = 6'd18;
  localparam logic [5:0] KLess    = 6'd20;
  localparam logic [5:0] KGreater = 6'd22;
  localparam logic [5:0] KString  = 6'd24;
  localparam logic [5:0] KNumber  = 6'd25;
  localparam logic [5:0] KIdent   = 6'd26;
  localparam logic [5:0] KKeyword0 = 6'd27;
  localparam logic [5:0] KBadChar = 6'd41;
  localparam logic [5:0] KUnterm  = 6'd42;

  typedef enum logic [3:0] {
    M_IDLE, M_OPPEND, M_NUMINT, M_NUMDOT, M_NUMFRAC,
    M_IDENT, M_STRING, M_COMMENT, M_DONE
  } mode_e;

  // keyword texts, byte 0 first, padded with zeros
  typedef logic [7:0] kw_word_t [6];
  localparam int unsigned NumKw = 14;

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] d);
    logic [47:0] w;
    case (k)
      4'd0:  w = {8'h0, "ssalc"};
      4'd1:  w = {16'h0, "esle"};
      4'd2:  w = {8'h0, "eslaf"};
      4'd3:  w = {24'h0, "rof"};
      4'd4:  w = {16'h0, "cnuf"};
      4'd5:  w = {32'h0, "fi"};
      4'd6:  w = {16'h0, "llun"};
      4'd7:  w = {8'h0, "tnirp"};
      4'd8:  w = "nruter";
      4'd9:  w = {8'h0, "repus"};
      4'd10: w = {16'h0, "siht"};
      4'd11: w = {16'h0, "eurt"};
      4'd12: w = {24'h0, "rav"};
      4'd13: w = {8'h0, "elihw"};
      default: w = '0;
    endcase
    case (d)
      3'd0: kw_char = w[7:0];
      3'd1: kw_char = w[15:8];
      3'd2: kw_char = w[23:16];
      3'd3: kw_char = w[31:24];
      3'd4: kw_char = w[39:32];
      3'd5: kw_char = w[47:40];
      default: kw_char = 8'h0;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd2, 4'd7, 4'd9, 4'd13: kw_len = 3'd5;
      4'd1, 4'd4, 4'd6, 4'd10, 4'd11: kw_len = 3'd4;
      4'd3, 4'd12: kw_len = 3'd3;
      4'd5: kw_len = 3'd2;
      4'd8: kw_len = 3'd6;
      default: kw_len = 3'd0;
    endcase
  endfunction

  // one token, as it goes from the scanner to the output side
  typedef struct packed {
    logic [5:0]          kind;
    logic [PosBits-1:0]  start;
    logic [PosBits-1:0]  len;
    logic [LineBits-1:0] line;
    logic                last;
  } token_t;

  // group of up to three tokens produced by one byte
  typedef struct packed {
    logic [1:0] count;
    token_t     t2;
    token_t     t1;
    token_t     t0;
  } bundle_t;

endpackage

// ===== design/sts_front.sv =====
// ----------------------------------------------------------------------------
// sts_front: byte classifier and scanner state machine
// Takes one byte or end marker per cycle while the queue has room and produces a bundle of tokens.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] ch_i,
  input  logic       eos_i,
  output logic       in_ready_o,
  output logic       push_o,
  output bundle_t    bundle_o,
  input  logic       queue_ready_i
);

  mode_e               mode_q, mode_d;
  logic [PosBits-1:0]  start_q, start_d;
  logic [PosBits-1:0]  pos_q, pos_d;
  logic [PosBits-1:0]  len_q, len_d;
  logic [LineBits-1:0] line_q, line_d;
  logic [4:0]          kw_q, kw_d;
  logic [5:0]          pend_q, pend_d;

  logic               fire;
  token_t             tok [3];
  logic [1:0]         n;
  logic [PosBits:0]   dot_sum;
  logic [PosBits-1:0] dot_start;

  assign in_ready_o = queue_ready_i;
  assign fire       = in_valid_i && queue_ready_i;

  // dot after a number sits right after the number text
  assign dot_sum   = {1'b0, start_q} + {1'b0, len_q};
  assign dot_start = dot_sum[PosBits] ? PosTop : dot_sum[PosBits-1:0];

  function automatic logic [PosBits-1:0] sat_add(input logic [PosBits-1:0] a,
                                                  input logic [1:0] b);
    logic [PosBits:0] s;
    s = {1'b0, a} + {{(PosBits-1){1'b0}}, b};
    sat_add = s[PosBits] ? PosTop : s[PosBits-1:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // keyword candidate step: cand is 1-based index, depth is matched length
  function automatic logic [4:0] kw_step(input logic [4:0] cand,
                                         input logic [PosBits-1:0] depth,
                                         input logic [7:0] c);
    logic [4:0] res;
    logic       pre;
    logic [3:0] ci;
    res = '0;
    ci  = cand[3:0] - 4'd1;
    if (depth < PosBits'(6) && !(depth != '0 && (cand == '0 || cand > 5'd14))) begin
      for (int k = NumKw - 1; k >= 0; k--) begin
        pre = 1'b1;
        for (int j = 0; j < 5; j++) begin
          if (PosBits'(j) < depth &&
              kw_char(4'(k), 3'(j)) != kw_char(ci, 3'(j))) pre = 1'b0;
        end
        if (depth < PosBits'(kw_len(4'(k))) && pre &&
            kw_char(4'(k), depth[2:0]) == c) res = 5'(k + 1);
      end
    end
    kw_step = res;
  endfunction

  // next state and tokens for one accepted item
  always_comb begin
    logic [LineBits-1:0] ln;
    logic [5:0]          ik;
    logic [7:0]          want;
    logic                do_idle;
    logic [PosBits-1:0]  p;
    mode_d  = mode_q;
    start_d = start_q;
    pos_d   = pos_q;
    len_d   = len_q;
    line_d  = line_q;
    kw_d    = kw_q;
    pend_d  = pend_q;
    n       = 2'd0;
    for (int i = 0; i < 3; i++) tok[i] = '0;
    ln = line_q;
    ik = (kw_q >= 5'd1 && kw_q <= 5'd14 && len_q == PosBits'(kw_len(kw_q[3:0] - 4'd1)))
         ? (KKeyword0 + {1'b0, kw_q} - 6'd1) : KIdent;
    want = (pend_q == KAmp) ? "&" : ((pend_q == KPipe) ? "|" : "=");
    do_idle = 1'b0;
    p = pos_q;
    if (mode_q != M_DONE) begin
      if (eos_i) begin
        unique case (mode_q)
          M_OPPEND: begin
            tok[0] = '{pend_q, start_q, PosBits'(1), ln, 1'b0}; n = 2'd1;
          end
          M_NUMINT, M_NUMFRAC: begin
            tok[0] = '{KNumber, start_q, len_q, ln, 1'b0}; n = 2'd1;
          end
          M_NUMDOT: begin
            tok[0] = '{KNumber, start_q, len_q, ln, 1'b0};
            tok[1] = '{KDot, dot_start, PosBits'(1), ln, 1'b0};
            n = 2'd2;
          end
          M_IDENT: begin
            tok[0] = '{ik, start_q, len_q, ln, 1'b0}; n = 2'd1;
          end
          M_STRING: begin
            tok[0] = '{KUnterm, start_q, len_q, ln, 1'b0}; n = 2'd1;
          end
          default: ;
        endcase
        tok[n] = '{KEof, pos_q, '0, ln, 1'b1};
        n      = n + 2'd1;
        mode_d = M_DONE;
        pend_d = '0;
      end else begin
        unique case (mode_q)
          M_OPPEND: begin
            if (pend_q == KSlash) begin
              if (ch_i == "/") mode_d = M_COMMENT;
              else begin
                tok[0] = '{KSlash, start_q, PosBits'(1), ln, 1'b0}; n = 2'd1;
                do_idle = 1'b1;
              end
            end else if (ch_i == want) begin
              tok[0] = '{pend_q + 6'd1, start_q, PosBits'(2), ln, 1'b0}; n = 2'd1;
              mode_d = M_IDLE;
            end else begin
              tok[0] = '{pend_q, start_q, PosBits'(1), ln, 1'b0}; n = 2'd1;
              do_idle = 1'b1;
            end
          end
          M_NUMINT: begin
            if (is_digit(ch_i)) len_d = sat_add(len_q, 2'd1);
            else if (ch_i == ".") mode_d = M_NUMDOT;
            else begin
              tok[0] = '{KNumber, start_q, len_q, ln, 1'b0}; n = 2'd1;
              do_idle = 1'b1;
            end
          end
          M_NUMDOT: begin
            if (is_digit(ch_i)) begin
              len_d  = sat_add(len_q, 2'd2);
              mode_d = M_NUMFRAC;
            end else begin
              tok[0] = '{KNumber, start_q, len_q, ln, 1'b0};
              tok[1] = '{KDot, dot_start, PosBits'(1), ln, 1'b0};
              n = 2'd2;
              do_idle = 1'b1;
            end
          end
          M_NUMFRAC: begin
            if (is_digit(ch_i)) len_d = sat_add(len_q, 2'd1);
            else begin
              tok[0] = '{KNumber, start_q, len_q, ln, 1'b0}; n = 2'd1;
              do_idle = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_digit(ch_i) || is_alpha(ch_i)) begin
              kw_d  = kw_step(kw_q, len_q, ch_i);
              len_d = sat_add(len_q, 2'd1);
            end else begin
              tok[0] = '{ik, start_q, len_q, ln, 1'b0}; n = 2'd1;
              kw_d = '0;
              do_idle = 1'b1;
            end
          end
          M_STRING: begin
            len_d = sat_add(len_q, 2'd1);
            if (ch_i == 8'h0a && line_q != LineTop) begin
              line_d = line_q + LineBits'(1);
            end
            if (ch_i == "\"") begin
              tok[0] = '{KString, start_q, sat_add(len_q, 2'd1), line_q, 1'b0}; n = 2'd1;
              mode_d = M_IDLE;
            end
          end
          M_COMMENT: begin
            if (ch_i == 8'h0a) do_idle = 1'b1;
          end
          default: do_idle = 1'b1;
        endcase
        // idle handling of the current byte
        if (do_idle) begin
          mode_d = M_IDLE;
          if (ch_i == 8'h0a) begin
            if (line_q != LineTop) line_d = line_q + LineBits'(1);
          end else if (ch_i == " " || ch_i == 8'h0d || ch_i == 8'h09) begin
          end else if (is_digit(ch_i)) begin
            mode_d = M_NUMINT; start_d = p; len_d = PosBits'(1);
          end else if (is_alpha(ch_i)) begin
            mode_d = M_IDENT; start_d = p; len_d = PosBits'(1);
            kw_d = kw_step('0, '0, ch_i);
          end else begin
            case (ch_i)
              "(": begin tok[n] = '{KLParen, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              ")": begin tok[n] = '{KRParen, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              "{": begin tok[n] = '{KLBrace, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              "}": begin tok[n] = '{KRBrace, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              ";": begin tok[n] = '{KSemi, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              ",": begin tok[n] = '{KComma, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              ".": begin tok[n] = '{KDot, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              "-": begin tok[n] = '{KMinus, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              "+": begin tok[n] = '{KPlus, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              "*": begin tok[n] = '{KStar, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
              "\"": begin mode_d = M_STRING; start_d = p; len_d = PosBits'(1); end
              "/": begin mode_d = M_OPPEND; start_d = p; len_d = PosBits'(1);
                pend_d = KSlash; end
              "&": begin mode_d = M_OPPEND; start_d = p; len_d = PosBits'(1);
                pend_d = KAmp; end
              "|": begin mode_d = M_OPPEND; start_d = p; len_d = PosBits'(1);
                pend_d = KPipe; end
              "!": begin mode_d = M_OPPEND; start_d = p; len_d = PosBits'(1);
                pend_d = KBang; end
              "=": begin mode_d = M_OPPEND; start_d = p; len_d = PosBits'(1);
                pend_d = KEqual; end
              "<": begin mode_d = M_OPPEND; start_d = p; len_d = PosBits'(1);
                pend_d = KLess; end
              ">": begin mode_d = M_OPPEND; start_d = p; len_d = PosBits'(1);
                pend_d = KGreater; end
              default: begin tok[n] = '{KBadChar, p, PosBits'(1), ln, 1'b0}; n = n + 2'd1; end
            endcase
          end
        end
        // pending operator clears once the scanner leaves that mode
        if (mode_q == M_OPPEND && mode_d != M_OPPEND) pend_d = '0;
        if (n != 2'd0) tok[n-2'd1].last = 1'b1;
        pos_d = sat_add(pos_q, 2'd1);
      end
    end
  end

  assign push_o            = fire && (n != 2'd0);
  assign bundle_o.count    = n;
  assign bundle_o.t0       = tok[0];
  assign bundle_o.t1       = tok[1];
  assign bundle_o.t2       = tok[2];

  // scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      line_q  <= LineBits'(1);
      kw_q    <= '0;
      pend_q  <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      line_q  <= line_d;
      kw_q    <= kw_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ===== design/sts_queue.sv =====
// ----------------------------------------------------------------------------
// sts_queue: two-entry bundle queue between scanner and output side
// Lets the scanner run while earlier tokens wait at the output.
// ----------------------------------------------------------------------------
module sts_queue import sts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output bundle_t data_o,
  input  logic    pop_i
);

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== design/sts_back.sv =====
// ----------------------------------------------------------------------------
// sts_back: token serializer
// Sends the tokens of each bundle one per transfer on the output stream.
// ----------------------------------------------------------------------------
module sts_back import sts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  bundle_t data_i,
  output logic    pop_o,
  output logic    tvalid_o,
  output token_t  tok_o,
  input  logic    tready_i
);

  logic [1:0] idx_q;
  logic       xfer;

  assign tvalid_o = valid_i;
  assign xfer     = valid_i && tready_i;

  // pick current token
  always_comb begin
    case (idx_q)
      2'd0:    tok_o = data_i.t0;
      2'd1:    tok_o = data_i.t1;
      default: tok_o = data_i.t2;
    endcase
  end

  assign pop_o = xfer && (idx_q + 2'd1 == data_i.count);

  // token index within the bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 2'd0;
    else if (xfer) idx_q <= pop_o ? 2'd0 : idx_q + 2'd1;
  end

endmodule

// ===== design/script_token_scanner.sv =====
// ----------------------------------------------------------------------------
// script_token_scanner: streaming lexer top level
// Scanner front, two-bundle queue, and token serializer on the output.
// ----------------------------------------------------------------------------
// the tokens of each accepted byte pass through the registered bundle queue to the output
// throughput: one byte per cycle while the output is ready and each byte yields
//   at most one token; a byte giving more than one token sends them one per transfer
// reset: asynchronous, returns to idle, offset 0, line 1; no clearing pass
module script_token_scanner import sts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic        s_axis_tuser,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // token_kind, token_start, token_length, line_number
  output logic        m_axis_tlast    // last
);

  logic    push, q_ready, q_valid, pop;
  bundle_t f_bundle, q_bundle;
  token_t  tok;

  sts_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .ch_i(s_axis_tdata), .eos_i(s_axis_tuser),
    .in_ready_o(s_axis_tready), .push_o(push), .bundle_o(f_bundle),
    .queue_ready_i(q_ready)
  );

  sts_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_bundle), .ready_o(q_ready),
    .valid_o(q_valid), .data_o(q_bundle), .pop_i(pop)
  );

  sts_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .data_i(q_bundle), .pop_o(pop),
    .tvalid_o(m_axis_tvalid), .tok_o(tok), .tready_i(m_axis_tready)
  );

  // pack output fields
  assign m_axis_tdata = {2'b00, tok.line, tok.len, tok.start, tok.kind};
  assign m_axis_tlast = tok.last;

endmodule

// ===== design/sts_checker.sv =====
// ----------------------------------------------------------------------------
// sts_checker: port-level checks for the script token scanner
// Watches the output stream and attaches to the top level by bind.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled output holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // kind always in range
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[5:0] <= 6'd42)
    else $error("token kind out of range");

  // eof closes a group
  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5:0] == 6'd0 |-> m_axis_tlast)
    else $error("eof without last");

  // line never zero
  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[53:38] != 16'd0)
    else $error("line number zero");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
